FILE: rtl/core/bla_pkg.sv
// Shared types and constants for the byte list append/remove block.
// Holds field widths, request and status codes and the controller state type.
// No dependencies.
package bla_pkg;

  localparam int VAL_W     = 8;
  localparam int STATUS_W  = 2;
  localparam int CNT_OUT_W = 5;
  localparam int POS_OUT_W = 4;

  typedef enum logic {
    REQ_APPEND = 1'b0,
    REQ_REMOVE = 1'b1
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_FINISH
  } state_t;

endpackage

FILE: rtl/core/bla_req_if.sv
// Request channel: valid/ready handshake carrying one request word.
// Depends on bla_pkg for the byte width.
interface bla_req_if import bla_pkg::*; ();

  logic             valid;
  logic             ready;
  logic             req_type;
  logic [VAL_W-1:0] char_value;

  modport source (output valid, output req_type, output char_value, input ready);
  modport sink   (input valid, input req_type, input char_value, output ready);

endinterface

FILE: rtl/core/bla_rsp_if.sv
// Response channel: valid/ready handshake carrying one result word.
// Depends on bla_pkg for the field widths.
interface bla_rsp_if import bla_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [CNT_OUT_W-1:0] entry_count;
  logic [POS_OUT_W-1:0] removed_position;

  modport source (output valid, output status, output entry_count,
                  output removed_position, input ready);
  modport sink   (input valid, input status, input entry_count,
                  input removed_position, output ready);

endinterface

FILE: rtl/core/bla_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/byte_list_append_remove_core.sv
// Byte list with append and remove of the last occurrence of a byte value.
// An append, a full append or a remove on an empty list goes straight to the
// finish state; a remove scans down from the top, and a match below the top
// then shifts the entries above it down by one place before the finish.
// One request at a time; the next word is taken the cycle after the result
// is registered. Synchronous reset empties the list; entry data is not cleared.
module byte_list_append_remove_core import bla_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input logic       clk,
  input logic       rst,
  bla_req_if.sink   req,
  bla_rsp_if.source rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = CW + 1;

  state_t               state;
  state_t               state_next;
  logic [CW-1:0]        count;
  logic                 dec_count;
  logic [VAL_W-1:0]     val_reg;
  logic [AW-1:0]        scan_idx;
  logic [AW-1:0]        sh_idx;
  status_t              res_status;
  logic [AW-1:0]        res_pos;
  logic                 out_valid;
  status_t              out_status;
  logic [CNT_OUT_W-1:0] out_count;
  logic [POS_OUT_W-1:0] out_pos;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [VAL_W-1:0]     wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [VAL_W-1:0]     rd_data;

  logic accept;
  logic is_append;
  logic is_full;
  logic is_empty;
  logic match;
  logic at_top;
  logic shift_last;
  logic out_free;

  bla_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign req.ready  = (state == S_IDLE);
  assign accept     = req.valid && req.ready;
  assign is_append  = (req.req_type == REQ_APPEND);
  assign is_full    = (count >= CW'(CAPACITY));
  assign is_empty   = (count == '0);
  assign match      = (rd_data == val_reg);
  // The match sits at the top of the list, so nothing above it has to move.
  assign at_top     = (EW'(scan_idx) + EW'(1) == EW'(count));
  assign shift_last = (EW'(sh_idx) + EW'(2) == EW'(count));
  assign out_free   = !out_valid || rsp.ready;

  assign rsp.valid            = out_valid;
  assign rsp.status           = out_status;
  assign rsp.entry_count      = out_count;
  assign rsp.removed_position = out_pos;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (!is_append && !is_empty) begin
            state_next = S_SEARCH;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_SEARCH: begin
        if (match) begin
          state_next = at_top ? S_FINISH : S_SHIFT;
        end else if (scan_idx == '0) begin
          state_next = S_FINISH;
        end
      end
      S_SHIFT: begin
        if (shift_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // The scan walks down from the top, one read per cycle; the word compared in
  // a cycle is the one read in the previous cycle. The shift writes index i
  // while reading index i+2, so the two ports never touch the same entry.
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = val_reg;
    rd_en     = 1'b0;
    rd_addr   = '0;
    dec_count = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (is_append && !is_full) begin
            wr_en   = 1'b1;
            wr_addr = count[AW-1:0];
            wr_data = req.char_value;
          end else if (!is_append && !is_empty) begin
            rd_en   = 1'b1;
            rd_addr = AW'(count - CW'(1));
          end
        end
      end
      S_SEARCH: begin
        if (match) begin
          if (at_top) begin
            dec_count = 1'b1;
          end else begin
            rd_en   = 1'b1;
            rd_addr = scan_idx + AW'(1);
          end
        end else if (scan_idx != '0) begin
          rd_en   = 1'b1;
          rd_addr = scan_idx - AW'(1);
        end
      end
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = sh_idx;
        wr_data = rd_data;
        if (shift_last) begin
          dec_count = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = sh_idx + AW'(2);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && is_append && !is_full) begin
        count <= count + CW'(1);
      end else if (dec_count) begin
        count <= count - CW'(1);
      end
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          val_reg  <= req.char_value;
          scan_idx <= AW'(count - CW'(1));
          res_pos  <= '0;
          if (is_append) begin
            res_status <= is_full ? ST_FULL : ST_DONE;
          end else begin
            res_status <= is_empty ? ST_NOT_FOUND : ST_DONE;
          end
        end
      end
      S_SEARCH: begin
        if (match) begin
          res_pos <= scan_idx;
          sh_idx  <= scan_idx;
        end else if (scan_idx == '0) begin
          res_status <= ST_NOT_FOUND;
        end else begin
          scan_idx <= scan_idx - AW'(1);
        end
      end
      S_SHIFT: begin
        sh_idx <= sh_idx + AW'(1);
      end
      S_FINISH: begin
        if (out_free) begin
          out_status <= res_status;
          out_count  <= CNT_OUT_W'(count);
          out_pos    <= POS_OUT_W'(res_pos);
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_no_port_collision: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en && (wr_addr == rd_addr)))
    else $error("entry read and written at the same address in one cycle");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("list count exceeds capacity");

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (count != $past(count))) |->
      ((count == $past(count) + CW'(1)) || (count == $past(count) - CW'(1))))
    else $error("list count changed by more than one");

  a_write_in_list: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (CW'(wr_addr) <= count))
    else $error("entry written beyond the end of the list");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    dec_count |=> (state == S_FINISH))
    else $error("count lowered outside the end of a remove");
`endif

endmodule
